// ===== rtl/core/fcoe_enc_pkg.sv =====
// Shared types and constants of the FCoE frame encapsulator.
package fcoe_enc_pkg;

  localparam int unsigned STEP_W     = 6;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned HOLD_DEPTH = 16;
  localparam int unsigned HOLD_IDX_W = 4;
  localparam int unsigned MAC_W      = 48;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MAC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_MAC   = 1'd1;

  // Header burst layout, one step per output byte
  localparam logic [STEP_W-1:0] HDR_DMAC   = 6'd0;
  localparam logic [STEP_W-1:0] HDR_SMAC   = 6'd6;
  localparam logic [STEP_W-1:0] HDR_ETH_HI = 6'd12;
  localparam logic [STEP_W-1:0] HDR_ETH_LO = 6'd13;
  localparam logic [STEP_W-1:0] HDR_PAD    = 6'd14;
  localparam logic [STEP_W-1:0] HDR_SOF    = 6'd27;
  localparam logic [STEP_W-1:0] HDR_HOLD   = 6'd28;
  localparam logic [STEP_W-1:0] HDR_LAST   = 6'd43;

  // Trailer burst layout
  localparam logic [STEP_W-1:0] TRL_CRC_LAST = 6'd3;
  localparam logic [STEP_W-1:0] TRL_EOF      = 6'd4;
  localparam logic [STEP_W-1:0] TRL_LAST     = 6'd7;

  // Positions within the held FC header
  localparam logic [COUNT_W-1:0] ESEQ_IDX  = 5'd9;
  localparam logic [COUNT_W-1:0] SEQCNT_HI = 5'd14;
  localparam logic [COUNT_W-1:0] SEQCNT_LO = 5'd15;
  localparam logic [COUNT_W-1:0] HOLD_FULL = 5'd16;
  localparam logic [COUNT_W-1:0] HOLD_LAST = 5'd15;

  localparam logic [7:0]  ETHTYPE_HI = 8'h89;
  localparam logic [7:0]  ETHTYPE_LO = 8'h06;
  localparam logic [7:0]  SOF_I3     = 8'h2E;
  localparam logic [7:0]  SOF_N3     = 8'h36;
  localparam logic [7:0]  EOF_T      = 8'h42;
  localparam logic [7:0]  EOF_N      = 8'h41;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

  typedef enum logic [1:0] {
    SRC_IN,
    SRC_SHORT,
    SRC_HDR,
    SRC_TRL
  } src_e;

  typedef struct packed {
    logic              accept;
    logic              emit;
    src_e              src;
    logic [STEP_W-1:0] step;
    logic              frame_end;
    logic              run_last;
    logic              clear;
  } cmd_t;

  typedef struct packed {
    logic hold_short;  // this byte leaves the header still incomplete
    logic hold_full;   // header already sent, bytes pass through
  } status_t;

endpackage

// ===== rtl/core/fcoe_enc_ctrl.sv =====
// Controller: input handshake, header and trailer sequencing, output valid.
module fcoe_enc_ctrl
  import fcoe_enc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    fc_last_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HDR  = 2'd1;
  localparam logic [1:0] ST_TRL  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;
  logic              acc;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && slot_free);
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    last_d          = last_q;
    cmd_o           = '0;
    cmd_o.src       = SRC_IN;
    cmd_o.step      = step_q;
    cmd_o.accept    = acc;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (status_i.hold_full) begin
            cmd_o.emit     = 1'b1;
            cmd_o.src      = SRC_IN;
            cmd_o.run_last = !fc_last_i;
            if (fc_last_i) begin
              state_d = ST_TRL;
              step_d  = '0;
            end
          end else if (status_i.hold_short) begin
            if (fc_last_i) begin
              // drop the short frame with a single status transfer
              cmd_o.emit     = 1'b1;
              cmd_o.src      = SRC_SHORT;
              cmd_o.run_last = 1'b1;
              cmd_o.clear    = 1'b1;
            end
          end else begin
            state_d = ST_HDR;
            step_d  = '0;
            last_d  = fc_last_i;
          end
        end
      end
      ST_HDR: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_HDR;
          if (step_q == HDR_LAST) begin
            cmd_o.run_last = !last_q;
            state_d        = last_q ? ST_TRL : ST_IDLE;
            step_d         = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      ST_TRL: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_TRL;
          if (step_q == TRL_LAST) begin
            cmd_o.frame_end = 1'b1;
            cmd_o.run_last  = 1'b1;
            cmd_o.clear     = 1'b1;
            state_d         = ST_IDLE;
            step_d          = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/fcoe_enc_dp.sv =====
// Datapath: header hold, CRC, frame flags, MAC registers and output byte register.
module fcoe_enc_dp
  import fcoe_enc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MAC_W-1:0]     cfg_wdata_i,
  input  logic [7:0]           fc_byte_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  output logic [7:0]           out_byte_o,
  output logic                 frame_end_o,
  output logic                 run_last_o,
  output logic                 status_bit_o
);

  logic [MAC_W-1:0]   source_mac_q;
  logic [MAC_W-1:0]   dest_mac_q;
  logic [7:0]         hold_q [HOLD_DEPTH];
  logic [COUNT_W-1:0] count_q, count_d;
  logic [31:0]        crc_q, crc_d;
  logic               eseq_q, eseq_d;
  logic               seq_zero_q;
  logic               store;

  logic [7:0]         out_byte_q;
  logic               frame_end_q;
  logic               run_last_q;
  logic               status_q;

  logic [7:0]         byte_d;
  logic [7:0]         hdr_byte;
  logic [7:0]         trl_byte;
  logic [MAC_W-1:0]   mac_sel;
  logic [2:0]         mac_off;
  logic [MAC_W-1:0]   mac_shift;
  logic [STEP_W-1:0]  hold_rel;
  logic [31:0]        crc_out;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign store = cmd_i.accept && !status_o.hold_full;

  assign status_o.hold_full  = (count_q == HOLD_FULL);
  assign status_o.hold_short = (count_q < HOLD_LAST);

  always_comb begin
    if (cmd_i.clear) begin
      crc_d   = CRC_INIT;
      count_d = '0;
      eseq_d  = 1'b0;
    end else begin
      crc_d   = cmd_i.accept ? crc_byte(crc_q, fc_byte_i) : crc_q;
      count_d = store ? count_q + 1'b1 : count_q;
      eseq_d  = (store && count_q == ESEQ_IDX) ? fc_byte_i[3] : eseq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_mac_q <= '0;
      dest_mac_q   <= '0;
      count_q      <= '0;
      crc_q        <= CRC_INIT;
      eseq_q       <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_SOURCE_MAC) begin
        source_mac_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_DEST_MAC) begin
        dest_mac_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      crc_q   <= crc_d;
      eseq_q  <= eseq_d;
    end
  end

  // Hold the header bytes; track whether SEQ_CNT is zero as they arrive
  always_ff @(posedge clk_i) begin
    if (store) begin
      hold_q[count_q[HOLD_IDX_W-1:0]] <= fc_byte_i;
      if (count_q == SEQCNT_HI) begin
        seq_zero_q <= (fc_byte_i == 8'd0);
      end else if (count_q == SEQCNT_LO) begin
        seq_zero_q <= seq_zero_q && (fc_byte_i == 8'd0);
      end
    end
  end

  // MAC bytes go out most significant first
  always_comb begin
    if (cmd_i.step < HDR_SMAC) begin
      mac_sel = dest_mac_q;
      mac_off = cmd_i.step[2:0];
    end else begin
      mac_sel = source_mac_q;
      mac_off = 3'(cmd_i.step - HDR_SMAC);
    end
    mac_shift = mac_sel << {mac_off, 3'b000};
  end

  assign hold_rel = cmd_i.step - HDR_HOLD;

  always_comb begin
    case (cmd_i.step) inside
      [HDR_DMAC:HDR_ETH_HI - 6'd1]: hdr_byte = mac_shift[MAC_W-1 -: 8];
      HDR_ETH_HI:                    hdr_byte = ETHTYPE_HI;
      HDR_ETH_LO:                    hdr_byte = ETHTYPE_LO;
      [HDR_PAD:HDR_SOF - 6'd1]:      hdr_byte = 8'd0;
      HDR_SOF:                       hdr_byte = seq_zero_q ? SOF_I3 : SOF_N3;
      default:                       hdr_byte = hold_q[hold_rel[HOLD_IDX_W-1:0]];
    endcase
  end

  assign crc_out = ~crc_q;

  always_comb begin
    case (cmd_i.step) inside
      [6'd0:TRL_CRC_LAST]: trl_byte = crc_out[{cmd_i.step[1:0], 3'b000} +: 8];
      TRL_EOF:             trl_byte = eseq_q ? EOF_T : EOF_N;
      default:             trl_byte = 8'd0;
    endcase
  end

  always_comb begin
    case (cmd_i.src)
      SRC_IN:    byte_d = fc_byte_i;
      SRC_SHORT: byte_d = 8'd0;
      SRC_HDR:   byte_d = hdr_byte;
      SRC_TRL:   byte_d = trl_byte;
      default:   byte_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q  <= byte_d;
      frame_end_q <= cmd_i.frame_end;
      run_last_q  <= cmd_i.run_last;
      status_q    <= (cmd_i.src == SRC_SHORT);
    end
  end

  assign out_byte_o   = out_byte_q;
  assign frame_end_o  = frame_end_q;
  assign run_last_o   = run_last_q;
  assign status_bit_o = status_q;

endmodule

// ===== rtl/core/fcoe_frame_encapsulator.sv =====
// FCoE frame encapsulator top level: controller and datapath.
//
// Takes a Fibre Channel frame and sends out the FCoE Ethernet frame, both one
// byte per transfer. Unless output stall holds them, the first fifteen bytes
// of a frame are taken one per cycle with no output and later bytes pass
// through at one per cycle. The sixteenth starts a 44-byte header burst (MACs,
// ethertype, reserved bytes, SOF, held FC header) and the last byte is followed
// by an 8-byte trailer (CRC-32, EOF, padding); both stall input. The stalls
// come from the single output byte register, loaded once per cycle; output
// stall lengthens them. A frame ending before sixteen bytes yields one
// transfer with status set. source_mac (index 0) and dest_mac (index 1) must
// be written only while idle; the block itself does not enforce it.
module fcoe_frame_encapsulator
  import fcoe_enc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MAC_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           fc_byte_i,
  input  logic                 fc_last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 frame_end_o,
  output logic                 run_last_o,
  output logic                 status_o
);

  cmd_t    cmd;
  status_t dp_status;

  fcoe_enc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .fc_last_i   (fc_last_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  fcoe_enc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fc_byte_i    (fc_byte_i),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .out_byte_o   (out_byte_o),
    .frame_end_o  (frame_end_o),
    .run_last_o   (run_last_o),
    .status_bit_o (status_o)
  );

endmodule

// ===== tb/fcoe_encap_checker.sv =====
// Checker for the FCoE encapsulator: predicts the Ethernet bytes and compares each transfer.
module fcoe_encap_checker
  import fcoe_enc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MAC_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [7:0]           fc_byte_i,
  input  logic                 fc_last_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [7:0]           out_byte_i,
  input  logic                 frame_end_i,
  input  logic                 run_last_i,
  input  logic                 status_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       fend;
    logic       rlast;
    logic       stat;
  } enc_out_t;

  enc_out_t             enc_bytes_q[$];
  enc_out_t             burst_q[$];
  logic [7:0]           hdr_hold [HOLD_DEPTH];
  logic [COUNT_W-1:0]   fc_count;
  logic [31:0]          crc_acc;
  logic                 eseq_flag;
  logic [MAC_W-1:0]     src_mac;
  logic [MAC_W-1:0]     dst_mac;
  int unsigned          mismatches;
  int unsigned          pending;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void queue_out(input logic [7:0] d, input logic fe, input logic st);
    enc_out_t e;
    e.data  = d;
    e.fend  = fe;
    e.rlast = 1'b0;
    e.stat  = st;
    burst_q.push_back(e);
  endfunction

  function automatic void frame_restart();
    fc_count  = '0;
    crc_acc   = CRC_INIT;
    eseq_flag = 1'b0;
  endfunction

  // Work out every Ethernet byte that one FC byte causes
  function automatic void encap_fc_byte(input logic [7:0] b, input logic last);
    logic        hdr_open;
    logic [31:0] fcs;
    hdr_open = 1'b0;
    burst_q.delete();
    crc_acc = crc_next(crc_acc, b);
    if (fc_count < HOLD_FULL) begin
      hdr_hold[fc_count[HOLD_IDX_W-1:0]] = b;
      if (fc_count == ESEQ_IDX) eseq_flag = b[3];
      fc_count = fc_count + 5'd1;
      if (fc_count < HOLD_FULL) begin
        hdr_open = 1'b1;
      end else begin
        for (int k = 5; k >= 0; k--) queue_out(dst_mac[8*k +: 8], 1'b0, 1'b0);
        for (int k = 5; k >= 0; k--) queue_out(src_mac[8*k +: 8], 1'b0, 1'b0);
        queue_out(ETHTYPE_HI, 1'b0, 1'b0);
        queue_out(ETHTYPE_LO, 1'b0, 1'b0);
        for (int k = 0; k < 13; k++) queue_out(8'h00, 1'b0, 1'b0);
        if (hdr_hold[SEQCNT_HI[HOLD_IDX_W-1:0]] == 8'h00 &&
            hdr_hold[SEQCNT_LO[HOLD_IDX_W-1:0]] == 8'h00) begin
          queue_out(SOF_I3, 1'b0, 1'b0);
        end else begin
          queue_out(SOF_N3, 1'b0, 1'b0);
        end
        for (int k = 0; k < HOLD_DEPTH; k++) queue_out(hdr_hold[k], 1'b0, 1'b0);
      end
    end else begin
      queue_out(b, 1'b0, 1'b0);
    end

    if (hdr_open) begin
      // a frame ending before its header is complete is dropped
      if (last) begin
        queue_out(8'h00, 1'b0, 1'b1);
        frame_restart();
      end
    end else if (last) begin
      fcs = ~crc_acc;
      queue_out(fcs[7:0], 1'b0, 1'b0);
      queue_out(fcs[15:8], 1'b0, 1'b0);
      queue_out(fcs[23:16], 1'b0, 1'b0);
      queue_out(fcs[31:24], 1'b0, 1'b0);
      queue_out(eseq_flag ? EOF_T : EOF_N, 1'b0, 1'b0);
      queue_out(8'h00, 1'b0, 1'b0);
      queue_out(8'h00, 1'b0, 1'b0);
      queue_out(8'h00, 1'b1, 1'b0);
      frame_restart();
    end

    if (burst_q.size() > 0) begin
      burst_q[burst_q.size()-1].rlast = 1'b1;
      foreach (burst_q[k]) enc_bytes_q.push_back(burst_q[k]);
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    enc_out_t want;
    if (!rst_ni) begin
      src_mac = '0;
      dst_mac = '0;
      foreach (hdr_hold[k]) hdr_hold[k] = 8'h00;
      frame_restart();
      enc_bytes_q.delete();
      mismatches = 0;
      pending    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SOURCE_MAC: src_mac = cfg_wdata_i;
          CFG_DEST_MAC:   dst_mac = cfg_wdata_i;
        endcase
      end
      if (in_valid_i && !in_stall_i) encap_fc_byte(fc_byte_i, fc_last_i);
      if (out_valid_i && !out_stall_i) begin
        if (enc_bytes_q.size() == 0) begin
          $display("%0t: transfer with none pending, expected none, actual %h %b %b %b",
                   $time, out_byte_i, frame_end_i, run_last_i, status_i);
          mismatches++;
        end else begin
          want = enc_bytes_q.pop_front();
          check_field("out_byte", want.data, out_byte_i);
          check_field("frame_end", {7'd0, want.fend}, {7'd0, frame_end_i});
          check_field("run_last", {7'd0, want.rlast}, {7'd0, run_last_i});
          check_field("status", {7'd0, want.stat}, {7'd0, status_i});
        end
      end
      pending = enc_bytes_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top of the FCoE encapsulator: clock, reset, stimulus and verdict.
module tb_top;
  import fcoe_enc_pkg::*;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MAC_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic [7:0]           fc_byte   = 8'h00;
  logic                 fc_last   = 1'b0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [7:0]           out_byte;
  logic                 frame_end;
  logic                 run_last;
  logic                 status;

  bit                   gaps_on  = 1'b1;
  bit                   stall_on = 1'b1;
  int unsigned          items_sent;
  int unsigned          mismatch_count;
  int unsigned          pending;

  always #5 clk = ~clk;

  fcoe_frame_encapsulator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .fc_byte_i   (fc_byte),
    .fc_last_i   (fc_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .frame_end_o (frame_end),
    .run_last_o  (run_last),
    .status_o    (status)
  );

  fcoe_encap_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .fc_byte_i        (fc_byte),
    .fc_last_i        (fc_last),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_byte_i       (out_byte),
    .frame_end_i      (frame_end),
    .run_last_i       (run_last),
    .status_i         (status),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Present one FC byte and hold it until the transfer happens
  task automatic put_fc_byte(input logic [7:0] b, input logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    fc_byte  <= b;
    fc_last  <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_frame(input int unsigned len, input bit seq_zero, input bit eseq);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 9) b[3] = eseq;
      if ((i == 14 || i == 15) && seq_zero) b = 8'h00;
      put_fc_byte(b, i == len - 1);
    end
  endtask

  // Drop valid, let the checker see the last transfer, then wait for the block to drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic load_macs(input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SOURCE_MAC;
    cfg_wdata <= src;
    @(posedge clk);
    cfg_index <= CFG_DEST_MAC;
    cfg_wdata <= dst;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [7:0]  b;
    int unsigned phase_start;
    int unsigned len;
    int unsigned r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_macs(48'h0, 48'hFFFF_FFFF_FFFF);
    // dropped one-byte frame, then a 17-byte frame with End_Sequence and SEQ_CNT zero
    put_fc_byte(8'hFF, 1'b1);
    for (int i = 0; i < 17; i++) begin
      b = (i == 9 || i == 16) ? 8'hFF : 8'h00;
      put_fc_byte(b, i == 16);
    end

    for (int phase = 0; phase < 3; phase++) begin
      settle();
      if (phase == 0) begin
        load_macs(48'hFFFF_FFFF_FFFF, 48'h0);
      end else begin
        load_macs(MAC_W'({$urandom, $urandom}), MAC_W'({$urandom, $urandom}));
      end
      if (phase == 2) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end
      phase_start = items_sent;
      while (items_sent - phase_start < 75) begin
        r = $urandom_range(0, 9);
        if (r < 2) len = $urandom_range(1, 15);
        else if (r < 9) len = $urandom_range(16, 24);
        else len = $urandom_range(25, 64);
        send_frame(len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end

    settle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== fcoe_frame_encapsulator.f =====
rtl/core/fcoe_enc_pkg.sv
rtl/core/fcoe_enc_ctrl.sv
rtl/core/fcoe_enc_dp.sv
rtl/core/fcoe_frame_encapsulator.sv
tb/fcoe_encap_checker.sv
tb/tb_top.sv
